>>> sv/cau_pkg.sv
package cau_pkg;

    localparam int DATA_WIDTH  = 32;
    localparam int FRAC_BITS   = 16;

    // product, signed sum and magnitude, and divider remainder widths
    localparam int PW = 2 * DATA_WIDTH;
    localparam int SW = 2 * DATA_WIDTH + 1;
    localparam int RW = 3 * DATA_WIDTH + 1;
    localparam int QW = DATA_WIDTH + 1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [SW-1:0] NEG_LIM  = {{(SW-1){1'b0}}, 1'b1} << (DATA_WIDTH - 1);
    localparam logic [SW-1:0] POS_LIM  = NEG_LIM - {{(SW-1){1'b0}}, 1'b1};
    localparam logic [SW-1:0] ROUND_HALF =
        (FRAC_BITS > 0) ? ({{(SW-1){1'b0}}, 1'b1} << (FRAC_BITS - 1)) : '0;
    localparam logic [DATA_WIDTH-1:0] MAX_POS = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] MIN_NEG = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_SAT  = 2'd1,
        ST_DIV0 = 2'd2
    } status_t;

    typedef struct packed {
        op_t                            op;
        logic                           div_zero;
        logic signed [DATA_WIDTH-1:0]   a_re;
        logic signed [DATA_WIDTH-1:0]   a_im;
        logic signed [DATA_WIDTH-1:0]   b_re;
        logic signed [DATA_WIDTH-1:0]   b_im;
    } cau_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

    typedef struct packed {
        logic                   flag;
        logic [DATA_WIDTH-1:0]  value;
    } sat_t;

    function automatic sat_t saturate(input logic neg, input logic [SW-1:0] mag);
        sat_t r;
        r.flag  = 1'b0;
        r.value = neg ? (~mag[DATA_WIDTH-1:0] + 1'b1) : mag[DATA_WIDTH-1:0];
        if (mag > (neg ? NEG_LIM : POS_LIM))
        begin
            r.flag  = 1'b1;
            r.value = neg ? MIN_NEG : MAX_POS;
        end
        return r;
    endfunction

endpackage

>>> sv/cau_front.sv
module cau_front
    import cau_pkg::*;
(
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    req_type,
    input  logic signed [DATA_WIDTH-1:0]  a_re,
    input  logic signed [DATA_WIDTH-1:0]  a_im,
    input  logic signed [DATA_WIDTH-1:0]  b_re,
    input  logic signed [DATA_WIDTH-1:0]  b_im,
    input  queue_stat_t                   q_stat,
    output logic                          push,
    output cau_entry_t                    entry
);

    always_comb
    begin
        in_ready       = !q_stat.full;
        push           = in_valid && !q_stat.full;
        entry.op       = op_t'(req_type);
        entry.div_zero = (op_t'(req_type) == OP_DIV) && (b_re == '0) && (b_im == '0);
        entry.a_re     = a_re;
        entry.a_im     = a_im;
        entry.b_re     = b_re;
        entry.b_im     = b_im;
    end

endmodule

>>> sv/cau_queue.sv
module cau_queue
    import cau_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  cau_entry_t  push_data,
    input  logic        pop,
    output cau_entry_t  head,
    output queue_stat_t q_stat
);

    cau_entry_t          mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]     count_reg, count_next;

    always_comb
    begin
        wr_ptr_next  = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next  = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next   = count_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
        q_stat.full  = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
        q_stat.empty = (count_reg == '0);
        head         = mem_reg[rd_ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> sv/cau_back.sv
module cau_back
    import cau_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  cau_entry_t                    head,
    input  queue_stat_t                   q_stat,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [DATA_WIDTH-1:0]  res_re,
    output logic signed [DATA_WIDTH-1:0]  res_im,
    output logic [1:0]                    status
);

    typedef struct packed {
        logic                   is_div;
        logic [DATA_WIDTH-1:0]  res_re;
        logic [DATA_WIDTH-1:0]  res_im;
        status_t                status;
        logic                   neg_re;
        logic                   neg_im;
        logic                   big_re;
        logic                   big_im;
        logic [PW-1:0]          den;
        logic [RW-1:0]          rem_re;
        logic [RW-1:0]          rem_im;
        logic [DATA_WIDTH-1:0]  q_re;
        logic [DATA_WIDTH-1:0]  q_im;
    } div_stage_t;

    // one restoring step, quotient bit j
    function automatic div_stage_t div_step(input div_stage_t s, input int j);
        div_stage_t    r;
        logic [RW-1:0] dsh;
        r   = s;
        dsh = RW'(s.den) << j;
        if (s.rem_re >= dsh)
        begin
            r.rem_re    = s.rem_re - dsh;
            r.q_re[j]   = 1'b1;
        end
        if (s.rem_im >= dsh)
        begin
            r.rem_im    = s.rem_im - dsh;
            r.q_im[j]   = 1'b1;
        end
        return r;
    endfunction

    function automatic sat_t div_finish(input logic neg, input logic big,
                                        input logic [RW-1:0] rem, input logic [PW-1:0] den,
                                        input logic [DATA_WIDTH-1:0] q);
        sat_t          r;
        logic [QW-1:0] qr;
        qr = QW'(q) + QW'((rem << 1) >= RW'(den));
        r  = saturate(neg, SW'(qr));
        if (big)
        begin
            r.flag  = 1'b1;
            r.value = neg ? MIN_NEG : MAX_POS;
        end
        return r;
    endfunction

    logic adv;

    // stage 1: products and plain sums
    logic                        s1_vld_reg;
    op_t                         s1_op_reg;
    logic                        s1_zero_reg;
    logic signed [PW-1:0]        p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg, d_rr_reg, d_ii_reg;
    logic signed [DATA_WIDTH:0]  as_re_reg, as_im_reg;
    logic signed [PW-1:0]        p_rr_next, p_ii_next, p_ri_next, p_ir_next;
    logic signed [PW-1:0]        d_rr_next, d_ii_next;
    logic signed [DATA_WIDTH:0]  as_re_next, as_im_next;

    // stage 2: combined sums and divisor
    logic                        s2_vld_reg;
    op_t                         s2_op_reg;
    logic                        s2_zero_reg;
    logic signed [SW-1:0]        s_re_reg, s_im_reg, s_re_next, s_im_next;
    logic [PW-1:0]               den_reg, den_next;

    // sign/magnitude, non-divide results, then divider steps
    logic [SW-1:0]               mag_re, mag_im, rnd_re, rnd_im;
    logic                        neg_re, neg_im;
    sat_t                        sat_re, sat_im;
    div_stage_t                  dv_reg  [DATA_WIDTH+1];
    div_stage_t                  dv_next [DATA_WIDTH+1];
    logic [DATA_WIDTH:0]         dv_vld_reg;

    logic                        out_vld_reg;
    logic [DATA_WIDTH-1:0]       res_re_reg, res_im_reg, res_re_next, res_im_next;
    status_t                     status_reg, status_next;
    sat_t                        fin_re, fin_im;

    assign adv = !out_vld_reg || out_ready;
    assign pop = adv && !q_stat.empty;

    always_comb
    begin
        p_rr_next = head.a_re * head.b_re;
        p_ii_next = head.a_im * head.b_im;
        p_ri_next = head.a_re * head.b_im;
        p_ir_next = head.a_im * head.b_re;
        d_rr_next = head.b_re * head.b_re;
        d_ii_next = head.b_im * head.b_im;
        if (head.op == OP_SUB)
        begin
            as_re_next = {head.a_re[DATA_WIDTH-1], head.a_re}
                       - {head.b_re[DATA_WIDTH-1], head.b_re};
            as_im_next = {head.a_im[DATA_WIDTH-1], head.a_im}
                       - {head.b_im[DATA_WIDTH-1], head.b_im};
        end
        else
        begin
            as_re_next = {head.a_re[DATA_WIDTH-1], head.a_re}
                       + {head.b_re[DATA_WIDTH-1], head.b_re};
            as_im_next = {head.a_im[DATA_WIDTH-1], head.a_im}
                       + {head.b_im[DATA_WIDTH-1], head.b_im};
        end
    end

    always_comb
    begin
        den_next = $unsigned(d_rr_reg) + $unsigned(d_ii_reg);
        case (s1_op_reg)
            OP_MUL:
            begin
                s_re_next = {p_rr_reg[PW-1], p_rr_reg} - {p_ii_reg[PW-1], p_ii_reg};
                s_im_next = {p_ri_reg[PW-1], p_ri_reg} + {p_ir_reg[PW-1], p_ir_reg};
            end
            OP_DIV:
            begin
                // numerator of A * conj(B)
                s_re_next = {p_rr_reg[PW-1], p_rr_reg} + {p_ii_reg[PW-1], p_ii_reg};
                s_im_next = {p_ir_reg[PW-1], p_ir_reg} - {p_ri_reg[PW-1], p_ri_reg};
            end
            default:
            begin
                s_re_next = SW'(as_re_reg);
                s_im_next = SW'(as_im_reg);
            end
        endcase
    end

    always_comb
    begin
        neg_re = s_re_reg[SW-1];
        neg_im = s_im_reg[SW-1];
        mag_re = neg_re ? -s_re_reg : s_re_reg;
        mag_im = neg_im ? -s_im_reg : s_im_reg;
        rnd_re = (s2_op_reg == OP_MUL) ? ((mag_re + ROUND_HALF) >> FRAC_BITS) : mag_re;
        rnd_im = (s2_op_reg == OP_MUL) ? ((mag_im + ROUND_HALF) >> FRAC_BITS) : mag_im;
        sat_re = saturate(neg_re, rnd_re);
        sat_im = saturate(neg_im, rnd_im);

        dv_next[0].is_div = (s2_op_reg == OP_DIV) && !s2_zero_reg;
        dv_next[0].neg_re = neg_re;
        dv_next[0].neg_im = neg_im;
        dv_next[0].den    = den_reg;
        dv_next[0].rem_re = RW'(mag_re) << FRAC_BITS;
        dv_next[0].rem_im = RW'(mag_im) << FRAC_BITS;
        dv_next[0].big_re = (RW'(mag_re) << FRAC_BITS) >= (RW'(den_reg) << DATA_WIDTH);
        dv_next[0].big_im = (RW'(mag_im) << FRAC_BITS) >= (RW'(den_reg) << DATA_WIDTH);
        dv_next[0].q_re   = '0;
        dv_next[0].q_im   = '0;
        if (s2_zero_reg)
        begin
            dv_next[0].res_re = '0;
            dv_next[0].res_im = '0;
            dv_next[0].status = ST_DIV0;
        end
        else
        begin
            dv_next[0].res_re = sat_re.value;
            dv_next[0].res_im = sat_im.value;
            dv_next[0].status = (sat_re.flag || sat_im.flag) ? ST_SAT : ST_OK;
        end

        for (int k = 0; k < DATA_WIDTH; k++)
        begin
            dv_next[k+1] = div_step(dv_reg[k], DATA_WIDTH - 1 - k);
        end
    end

    always_comb
    begin
        fin_re = div_finish(dv_reg[DATA_WIDTH].neg_re, dv_reg[DATA_WIDTH].big_re,
                            dv_reg[DATA_WIDTH].rem_re, dv_reg[DATA_WIDTH].den,
                            dv_reg[DATA_WIDTH].q_re);
        fin_im = div_finish(dv_reg[DATA_WIDTH].neg_im, dv_reg[DATA_WIDTH].big_im,
                            dv_reg[DATA_WIDTH].rem_im, dv_reg[DATA_WIDTH].den,
                            dv_reg[DATA_WIDTH].q_im);
        if (dv_reg[DATA_WIDTH].is_div)
        begin
            res_re_next = fin_re.value;
            res_im_next = fin_im.value;
            status_next = (fin_re.flag || fin_im.flag) ? ST_SAT : ST_OK;
        end
        else
        begin
            res_re_next = dv_reg[DATA_WIDTH].res_re;
            res_im_next = dv_reg[DATA_WIDTH].res_im;
            status_next = dv_reg[DATA_WIDTH].status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            dv_vld_reg  <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_vld_reg  <= !q_stat.empty;
            s2_vld_reg  <= s1_vld_reg;
            dv_vld_reg  <= {dv_vld_reg[DATA_WIDTH-1:0], s2_vld_reg};
            out_vld_reg <= dv_vld_reg[DATA_WIDTH];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_op_reg   <= head.op;
            s1_zero_reg <= head.div_zero;
            p_rr_reg    <= p_rr_next;
            p_ii_reg    <= p_ii_next;
            p_ri_reg    <= p_ri_next;
            p_ir_reg    <= p_ir_next;
            d_rr_reg    <= d_rr_next;
            d_ii_reg    <= d_ii_next;
            as_re_reg   <= as_re_next;
            as_im_reg   <= as_im_next;
            s2_op_reg   <= s1_op_reg;
            s2_zero_reg <= s1_zero_reg;
            s_re_reg    <= s_re_next;
            s_im_reg    <= s_im_next;
            den_reg     <= den_next;
            for (int k = 0; k <= DATA_WIDTH; k++)
            begin
                dv_reg[k] <= dv_next[k];
            end
            res_re_reg  <= res_re_next;
            res_im_reg  <= res_im_next;
            status_reg  <= status_next;
        end
    end

    assign out_valid = out_vld_reg;
    assign res_re    = res_re_reg;
    assign res_im    = res_im_reg;
    assign status    = status_reg;

endmodule

>>> sv/complex_arithmetic_unit_core.sv
// Pipeline from input transaction to result valid:
//   queue, product stage, sum stage, DATA_WIDTH + 1 divider stages, output register.
// Throughput: one transaction per cycle unless out_ready stalls the output; every operation
//   runs through the same pipeline, one quotient bit per divider stage after the first.
// Reset: asynchronous, active low; clears queue pointers, queue count and pipeline valids only.
module complex_arithmetic_unit_core
    import cau_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    req_type,
    input  logic signed [DATA_WIDTH-1:0]  a_re,
    input  logic signed [DATA_WIDTH-1:0]  a_im,
    input  logic signed [DATA_WIDTH-1:0]  b_re,
    input  logic signed [DATA_WIDTH-1:0]  b_im,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [DATA_WIDTH-1:0]  res_re,
    output logic signed [DATA_WIDTH-1:0]  res_im,
    output logic [1:0]                    status
);

    queue_stat_t q_stat;
    logic        push;
    logic        pop;
    cau_entry_t  entry;
    cau_entry_t  head;

    cau_front u_front (
        .in_valid (in_valid),
        .in_ready (in_ready),
        .req_type (req_type),
        .a_re     (a_re),
        .a_im     (a_im),
        .b_re     (b_re),
        .b_im     (b_im),
        .q_stat   (q_stat),
        .push     (push),
        .entry    (entry)
    );

    cau_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (entry),
        .pop       (pop),
        .head      (head),
        .q_stat    (q_stat)
    );

    cau_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_stat    (q_stat),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res_re    (res_re),
        .res_im    (res_im),
        .status    (status)
    );

endmodule
